// ===== rtl/core/blw_pkg.sv =====
// Shared types, register indexes, controller commands and the exp table function
// for the beam likelihood weighting unit. No dependencies.
package blw_pkg;

    typedef struct packed {
        logic        kind;
        logic [9:0]  particle;
        logic [19:0] observed_range;
        logic        observed_infinite;
        logic [19:0] expected_range;
        logic        expected_infinite;
        logic [31:0] prior_weight;
        logic        last_beam;
        logic        scan_start;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        logic [9:0]  particle_out;
        logic [31:0] weight_out;
        logic        zero_total;
    } out_t;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_HIT_MIX    = 4'd0;
    localparam cfg_idx_t CFG_SHORT_MIX  = 4'd1;
    localparam cfg_idx_t CFG_MAX_MIX    = 4'd2;
    localparam cfg_idx_t CFG_RAND_MIX   = 4'd3;
    localparam cfg_idx_t CFG_HIT_SIGMA  = 4'd4;
    localparam cfg_idx_t CFG_SHORT_RATE = 4'd5;
    localparam cfg_idx_t CFG_MAX_RANGE  = 4'd6;
    localparam cfg_idx_t CFG_BEAMS      = 4'd7;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_MAG2,
        OP_SIG2,
        OP_XDIV,
        OP_HLOOK,
        OP_HMUL,
        OP_HACC,
        OP_SMUL1,
        OP_SLOOK,
        OP_SMUL2,
        OP_SMUL3,
        OP_SACC,
        OP_MAX,
        OP_RDIV,
        OP_RACC,
        OP_PZ,
        OP_CUBE1,
        OP_CUBE2,
        OP_SUMACC,
        OP_PDIV,
        OP_WMUL,
        OP_WSTORE,
        OP_QDIV,
        OP_QOUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        logic kind;
        logic skip;
        logic last;
        logic neg;
        logic below_max;
        logic div_busy;
    } dp_stat_t;

    // One entry of the exp(-x) table in Q1.16; step is the Q0.32 argument step.
    function automatic logic [16:0] exp_entry(input logic [63:0] step, input int k);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e;
        term = 64'h1_0000_0000;
        sum  = 64'h1_0000_0000;
        e    = 64'h1_0000_0000;
        for (int n = 1; n <= 20; n++) begin
            term = ((term * step) >> 32) / 64'(n);
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        for (int j = 1; j <= k; j++) begin
            e = (e * sum) >> 32;
        end
        return 17'((e + 64'd32768) >> 16);
    endfunction

endpackage

// ===== rtl/core/blw_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module blw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/core/blw_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by every division.
// Depends on nothing; the caller aligns the numerator into hi and lo parts.
module blw_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] num_hi,
    input  logic [31:0] num_lo,
    input  logic [47:0] den,
    input  logic [5:0]  steps,
    output logic        busy,
    output logic        ovf,
    output logic [31:0] quo
);
    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [47:0] rem_reg, rem_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] quo_reg, quo_next;
    logic [47:0] den_reg, den_next;
    logic        ovf_reg, ovf_next;
    logic [48:0] trial;
    logic [48:0] diff;
    logic        ge;

    always_comb begin
        trial     = {rem_reg, lo_reg[31]};
        ge        = trial >= {1'b0, den_reg};
        diff      = trial - {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        ovf_next  = ovf_reg;
        if (start) begin
            // The quotient fits only when the upper part is below the divisor.
            busy_next = 1'b1;
            cnt_next  = steps;
            rem_next  = num_hi;
            lo_next   = num_lo;
            quo_next  = '0;
            den_next  = den;
            ovf_next  = num_hi >= den;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[47:0] : trial[47:0];
            lo_next   = {lo_reg[30:0], 1'b0};
            quo_next  = {quo_reg[30:0], ge};
            cnt_next  = cnt_reg - 6'd1;
            busy_next = cnt_reg != 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        ovf_reg <= ovf_next;
    end

    assign busy = busy_reg;
    assign ovf  = ovf_reg;
    assign quo  = quo_reg;
endmodule

// ===== rtl/core/blw_dp.sv =====
// Datapath: configuration registers, item register, shared multiplier, divider,
// exp table, accumulators, weight memory and result register. Uses blw_pkg,
// blw_div and blw_ram.
module blw_dp import blw_pkg::*; #(
    parameter int PARTICLE_COUNT  = 1024,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  in_t                   s_data,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  cfg_wr_en,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output out_t                  m_data
);
    localparam int AW = $clog2(PARTICLE_COUNT);
    localparam int IW = $clog2(EXP_TABLE_DEPTH);
    localparam logic [63:0] EXP_STEP   = (64'd1 << 36) / EXP_TABLE_DEPTH;
    localparam logic [63:0] SLOT_RECIP = ((64'd1 << 27) + PARTICLE_COUNT - 1) / PARTICLE_COUNT;

    logic [16:0] exp_tab [EXP_TABLE_DEPTH];

    for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_tab
        assign exp_tab[k] = exp_entry(EXP_STEP, k);
    end

    logic [15:0] hit_mix_reg, short_mix_reg, max_mix_reg, rand_mix_reg;
    logic [15:0] hit_sigma_reg, short_rate_reg;
    logic [19:0] max_range_reg;
    logic [10:0] beams_reg;
    logic [31:0] beam_sum_reg;
    logic [47:0] total_reg;

    in_t         item_reg;
    logic [AW-1:0] slot_reg;
    logic [63:0] prod_reg;
    logic [55:0] num_reg;
    logic [16:0] e_reg;
    logic [27:0] pz_acc_reg;
    logic [16:0] pz_reg;
    out_t        out_reg;

    // Particle index modulo the store depth by reciprocal multiplication.
    logic [36:0] slot_prod;
    logic [26:0] slot_full;

    logic [19:0] mag;
    logic [15:0] sig_eff;
    logic [19:0] range_eff;
    logic [10:0] beams_eff;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    logic        div_start;
    logic [47:0] div_hi;
    logic [31:0] div_lo;
    logic [47:0] div_den;
    logic [5:0]  div_steps;
    logic        div_busy, div_ovf;
    logic [31:0] div_q;

    logic [19:0] lk_x;
    logic        lk_in;
    logic [32:0] lk_mul;
    logic [IW-1:0] lk_idx;
    logic [16:0] lk_val;

    logic [32:0] sum_ext;
    logic [31:0] w_sat;
    logic [48:0] total_ext;
    logic [31:0] rd_weight;
    logic        mem_we;

    always_comb begin
        slot_prod = 37'(s_data.particle) * 37'(SLOT_RECIP);
        slot_full = 27'(s_data.particle) - 27'(slot_prod[36:27]) * 27'(PARTICLE_COUNT);
    end

    always_comb begin
        mag = (item_reg.observed_range >= item_reg.expected_range)
            ? item_reg.observed_range - item_reg.expected_range
            : item_reg.expected_range - item_reg.observed_range;
        sig_eff   = (hit_sigma_reg == '0) ? 16'd1 : hit_sigma_reg;
        range_eff = (max_range_reg == '0) ? 20'd1 : max_range_reg;
        beams_eff = (beams_reg == '0) ? 11'd1 : beams_reg;
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MAG2:  begin mul_a = 32'(mag);            mul_b = 32'(mag);            end
            OP_SIG2:  begin mul_a = 32'(sig_eff);        mul_b = 32'(sig_eff);        end
            OP_HMUL:  begin mul_a = 32'(hit_mix_reg);    mul_b = 32'(e_reg);          end
            OP_SMUL1: begin
                mul_a = 32'(short_rate_reg);
                mul_b = 32'(item_reg.observed_range);
            end
            OP_SMUL2: begin mul_a = 32'(short_mix_reg);  mul_b = 32'(short_rate_reg); end
            OP_SMUL3: begin mul_a = prod_reg[31:0];      mul_b = 32'(e_reg);          end
            OP_CUBE1: begin mul_a = 32'(pz_reg);         mul_b = 32'(pz_reg);         end
            OP_CUBE2: begin mul_a = 32'(prod_reg[33:16]); mul_b = 32'(pz_reg);        end
            OP_WMUL:  begin mul_a = item_reg.prior_weight; mul_b = div_q;             end
            default:  begin end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    always_comb begin
        div_start = 1'b0;
        div_hi    = '0;
        div_lo    = '0;
        div_den   = '0;
        div_steps = '0;
        unique case (cmd.op)
            OP_XDIV: begin
                div_start = 1'b1;
                div_hi    = 48'(num_reg[55:20]);
                div_lo    = {num_reg[19:0], 12'd0};
                div_den   = 48'({prod_reg[31:0], 1'b0});
                div_steps = 6'd20;
            end
            OP_RDIV: begin
                div_start = 1'b1;
                div_lo    = {rand_mix_reg, 16'd0};
                div_den   = 48'(range_eff);
                div_steps = 6'd26;
            end
            OP_PDIV: begin
                div_start = 1'b1;
                div_lo    = beam_sum_reg;
                div_den   = 48'(beams_eff);
                div_steps = 6'd32;
            end
            OP_QDIV: begin
                div_start = 1'b1;
                div_hi    = 48'(rd_weight);
                div_den   = total_reg;
                div_steps = 6'd32;
            end
            default: begin end
        endcase
    end

    blw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_hi  (div_hi),
        .num_lo  (div_lo),
        .den     (div_den),
        .steps   (div_steps),
        .busy    (div_busy),
        .ovf     (div_ovf),
        .quo     (div_q)
    );

    always_comb begin
        if (cmd.op == OP_SLOOK) begin
            lk_x  = prod_reg[21:2];
            lk_in = prod_reg[35:22] == '0;
        end else begin
            lk_x  = div_q[19:0];
            lk_in = !div_ovf;
        end
        lk_mul = 33'(lk_x) * 33'(EXP_TABLE_DEPTH);
        lk_idx = lk_mul[20 +: IW];
        lk_val = lk_in ? exp_tab[lk_idx] : 17'd0;
    end

    always_comb begin
        sum_ext   = 33'(beam_sum_reg) + 33'(prod_reg[33:16]);
        w_sat     = (prod_reg[63:48] != '0) ? '1 : prod_reg[47:16];
        total_ext = 49'(total_reg) + 49'(w_sat);
        mem_we    = cmd.op == OP_WSTORE;
    end

    blw_ram #(
        .WIDTH (32),
        .DEPTH (PARTICLE_COUNT)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (slot_reg),
        .wr_data (w_sat),
        .rd_addr (slot_reg),
        .rd_data (rd_weight)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_mix_reg    <= 16'd32768;
            short_mix_reg  <= 16'd6554;
            max_mix_reg    <= 16'd3277;
            rand_mix_reg   <= 16'd6554;
            hit_sigma_reg  <= 16'd205;
            short_rate_reg <= 16'd25;
            max_range_reg  <= 20'd30720;
            beams_reg      <= 11'd60;
            beam_sum_reg   <= '0;
            total_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_HIT_MIX:    hit_mix_reg    <= cfg_wdata[15:0];
                    CFG_SHORT_MIX:  short_mix_reg  <= cfg_wdata[15:0];
                    CFG_MAX_MIX:    max_mix_reg    <= cfg_wdata[15:0];
                    CFG_RAND_MIX:   rand_mix_reg   <= cfg_wdata[15:0];
                    CFG_HIT_SIGMA:  hit_sigma_reg  <= cfg_wdata[15:0];
                    CFG_SHORT_RATE: short_rate_reg <= cfg_wdata[15:0];
                    CFG_MAX_RANGE:  max_range_reg  <= cfg_wdata;
                    CFG_BEAMS:      beams_reg      <= cfg_wdata[10:0];
                    default: begin end
                endcase
            end
            if (cmd.load && s_data.scan_start) begin
                total_reg <= '0;
            end
            if (cmd.op == OP_SUMACC) begin
                beam_sum_reg <= sum_ext[32] ? '1 : sum_ext[31:0];
            end
            if (cmd.op == OP_WSTORE) begin
                beam_sum_reg <= '0;
                total_reg    <= total_ext[48] ? '1 : total_ext[47:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
            slot_reg <= slot_full[AW-1:0];
        end
        unique case (cmd.op)
            OP_MAG2, OP_HMUL, OP_SMUL1, OP_SMUL2, OP_SMUL3,
            OP_CUBE1, OP_CUBE2, OP_WMUL: prod_reg <= mul_p;
            OP_SIG2: begin
                prod_reg <= mul_p;
                num_reg  <= {prod_reg[39:0], 16'd0};
            end
            OP_HLOOK, OP_SLOOK: e_reg <= lk_val;
            OP_HACC: pz_acc_reg <= 28'(prod_reg[31:16]);
            OP_SACC: pz_acc_reg <= pz_acc_reg + 28'(prod_reg[48:24]);
            OP_MAX: begin
                if (item_reg.observed_range == max_range_reg) begin
                    pz_acc_reg <= pz_acc_reg + 28'(max_mix_reg);
                end
            end
            OP_RACC: pz_acc_reg <= pz_acc_reg + 28'(div_q[25:0]);
            OP_PZ: pz_reg <= (pz_acc_reg > 28'd65536) ? 17'd65536 : pz_acc_reg[16:0];
            OP_WSTORE: begin
                out_reg.result_kind  <= 1'b0;
                out_reg.particle_out <= item_reg.particle;
                out_reg.weight_out   <= w_sat;
                out_reg.zero_total   <= 1'b0;
            end
            OP_QOUT: begin
                out_reg.result_kind  <= 1'b1;
                out_reg.particle_out <= item_reg.particle;
                out_reg.zero_total   <= total_reg == '0;
                if (total_reg == '0) begin
                    out_reg.weight_out <= '0;
                end else if (div_ovf) begin
                    out_reg.weight_out <= '1;
                end else begin
                    out_reg.weight_out <= div_q;
                end
            end
            default: begin end
        endcase
    end

    always_comb begin
        stat.kind      = item_reg.kind;
        stat.skip      = item_reg.observed_infinite | item_reg.expected_infinite;
        stat.last      = item_reg.last_beam;
        stat.neg       = item_reg.observed_range < item_reg.expected_range;
        stat.below_max = item_reg.observed_range < max_range_reg;
        stat.div_busy  = div_busy;
    end

    assign m_data = out_reg;
endmodule

// ===== rtl/core/blw_ctrl.sv =====
// Controller: sequences one transaction at a time through the datapath and
// owns the input ready and result valid. Uses blw_pkg.
module blw_ctrl import blw_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_MAG2, S_SIG2, S_XDIV, S_XWAIT, S_HLOOK, S_HMUL, S_HACC,
        S_SMUL1, S_SLOOK, S_SMUL2, S_SMUL3, S_SACC, S_MAX, S_RDIV, S_RWAIT, S_RACC,
        S_PZ, S_CUBE1, S_CUBE2, S_SUMACC, S_PDIV, S_PWAIT, S_WMUL, S_WSTORE,
        S_RDWAIT, S_QDIV, S_QWAIT, S_QOUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   emit;

    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        cmd.load   = s_valid && (state_reg == S_IDLE);
        cmd.op     = OP_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_valid) begin state_next = S_DISP; end
            S_DISP: begin
                if (stat.kind) begin
                    state_next = S_RDWAIT;
                end else if (stat.skip) begin
                    state_next = stat.last ? S_PDIV : S_IDLE;
                end else begin
                    state_next = S_MAG2;
                end
            end
            S_MAG2:   begin cmd.op = OP_MAG2;  state_next = S_SIG2;  end
            S_SIG2:   begin cmd.op = OP_SIG2;  state_next = S_XDIV;  end
            S_XDIV:   begin cmd.op = OP_XDIV;  state_next = S_XWAIT; end
            S_XWAIT:  if (!stat.div_busy) begin state_next = S_HLOOK; end
            S_HLOOK:  begin cmd.op = OP_HLOOK; state_next = S_HMUL;  end
            S_HMUL:   begin cmd.op = OP_HMUL;  state_next = S_HACC;  end
            S_HACC: begin
                cmd.op     = OP_HACC;
                state_next = stat.neg ? S_SMUL1 : S_MAX;
            end
            S_SMUL1:  begin cmd.op = OP_SMUL1; state_next = S_SLOOK; end
            S_SLOOK:  begin cmd.op = OP_SLOOK; state_next = S_SMUL2; end
            S_SMUL2:  begin cmd.op = OP_SMUL2; state_next = S_SMUL3; end
            S_SMUL3:  begin cmd.op = OP_SMUL3; state_next = S_SACC;  end
            S_SACC:   begin cmd.op = OP_SACC;  state_next = S_MAX;   end
            S_MAX: begin
                cmd.op     = OP_MAX;
                state_next = stat.below_max ? S_RDIV : S_PZ;
            end
            S_RDIV:   begin cmd.op = OP_RDIV;  state_next = S_RWAIT; end
            S_RWAIT:  if (!stat.div_busy) begin state_next = S_RACC; end
            S_RACC:   begin cmd.op = OP_RACC;  state_next = S_PZ;    end
            S_PZ:     begin cmd.op = OP_PZ;    state_next = S_CUBE1; end
            S_CUBE1:  begin cmd.op = OP_CUBE1; state_next = S_CUBE2; end
            S_CUBE2:  begin cmd.op = OP_CUBE2; state_next = S_SUMACC; end
            S_SUMACC: begin
                cmd.op     = OP_SUMACC;
                state_next = stat.last ? S_PDIV : S_IDLE;
            end
            S_PDIV:   begin cmd.op = OP_PDIV;  state_next = S_PWAIT; end
            S_PWAIT:  if (!stat.div_busy) begin state_next = S_WMUL; end
            S_WMUL:   begin cmd.op = OP_WMUL;  state_next = S_WSTORE; end
            // Results wait here until the output register can take them.
            S_WSTORE: begin
                if (out_free) begin
                    cmd.op     = OP_WSTORE;
                    state_next = S_IDLE;
                end
            end
            S_RDWAIT: state_next = S_QDIV;
            S_QDIV:   begin cmd.op = OP_QDIV;  state_next = S_QWAIT; end
            S_QWAIT:  if (!stat.div_busy) begin state_next = S_QOUT; end
            S_QOUT: begin
                if (out_free) begin
                    cmd.op     = OP_QOUT;
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
        emit         = (cmd.op == OP_WSTORE) || (cmd.op == OP_QOUT);
        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
endmodule

// ===== rtl/core/beam_likelihood_weighting_unit.sv =====
// Top level of the beam likelihood weighting unit: controller, datapath and
// configuration port. Uses blw_pkg, blw_ctrl and blw_dp.

// The unit scores particles with the four-part beam model and handles one
// transaction at a time. A finite beam adds the short term when the reading is
// short of the expected range and skips the random term when the reading is at
// or beyond the maximum range; a particle's last beam adds the normalization and
// the weight multiply. Beam and read timing is set by the shared divider, which
// produces one quotient bit per cycle (20 bits for the hit exponent argument, 26
// for the random term, 32 for the normalization and the read ratio), and by the
// single shared multiplier. A beam marked infinite and not last returns to idle
// without a result. A result waits in its own output register while the next
// item is accepted. The weight memory is not cleared: reading a particle never
// written gives an arbitrary weight. Configuration is to be written only while
// the unit is idle; the block itself does not enforce this.
module beam_likelihood_weighting_unit import blw_pkg::*; #(
    parameter int PARTICLE_COUNT  = 1024,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_wr_en,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);
    dp_cmd_t  cmd;
    dp_stat_t stat;

    blw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    blw_dp #(
        .PARTICLE_COUNT  (PARTICLE_COUNT),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_data    (m_data)
    );
endmodule

// ===== rtl/core/blw_chk.sv =====
// Port-level checker for the beam likelihood weighting unit, bound to the top.
// Uses blw_pkg.
module blw_chk import blw_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);
    // A result held back keeps its value until the transaction completes.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The unit works on one item at a time.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while busy");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_total |-> m_data.result_kind && (m_data.weight_out == '0))
        else $error("zero total flagged with nonzero weight or on an update");

    a_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.result_kind |-> !m_data.zero_total)
        else $error("update result flags a zero total");
endmodule

bind beam_likelihood_weighting_unit blw_chk u_chk (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the beam likelihood weighting unit.
// Depends on blw_pkg and beam_likelihood_weighting_unit; drives beam and read
// transactions with random idling and compares every result with a local predictor.
module testbench;
    import blw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_wr_en = 1'b0;
    cfg_idx_t cfg_index = CFG_HIT_MIX;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    beam_likelihood_weighting_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Predictor state.
    logic [63:0] exp_lut [256];
    logic [63:0] k_hit_mix, k_short_mix, k_max_mix, k_rand_mix;
    logic [63:0] k_sigma, k_rate, k_max_range, k_beams;
    logic [63:0] beam_sum, scan_total;
    logic [31:0] weight_mem [1024];

    in_t   pending_items[$];
    out_t  expected_results[$];
    int    error_count = 0;
    int    result_count = 0;
    int    read_count = 0;
    bit    hold_off_long = 1'b0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic void build_exp_lut();
        logic [63:0] a, sum, term, e;
        a = (64'd16 << 32) / 64'd256;
        sum = 64'h1_0000_0000; term = sum; e = sum;
        for (int n = 1; n <= 20; n++) begin
            term = ((term * a) >> 32) / 64'(n);
            if (n % 2) sum = sum - term; else sum = sum + term;
        end
        for (int k = 0; k < 256; k++) begin
            if (k > 0) e = (e * sum) >> 32;
            exp_lut[k] = (e + 64'd32768) >> 16;
        end
    endfunction

    function automatic logic [63:0] exp_neg(input logic [63:0] x);
        if (x >= (64'd16 << 16)) return 64'd0;
        return exp_lut[((x * 64'd256) >> 20) % 256];
    endfunction

    function automatic logic [63:0] beam_probability(input logic [63:0] obs,
                                                     input logic [63:0] expd);
        logic [63:0] pz, sig, mag, x, rng;
        bit neg;
        sig = (k_sigma != 0) ? k_sigma : 64'd1;
        neg = obs < expd;
        mag = neg ? expd - obs : obs - expd;
        x = ((mag * mag) << 16) / (64'd2 * sig * sig);
        pz = (k_hit_mix * exp_neg(x)) >> 16;
        if (neg) pz += (k_short_mix * k_rate * exp_neg((k_rate * obs) >> 2)) >> 24;
        if (obs == k_max_range) pz += k_max_mix;
        rng = (k_max_range != 0) ? k_max_range : 64'd1;
        if (obs < k_max_range) pz += (k_rand_mix * 64'd1024) / rng;
        return (pz > 64'd65536) ? 64'd65536 : pz;
    endfunction

    function automatic void predict_weight(input in_t it);
        logic [63:0] pz, cube, p, w, q;
        logic [9:0] slot;
        out_t r;
        slot = it.particle;
        if (it.scan_start) scan_total = 0;
        if (it.kind) begin
            w = 64'(weight_mem[slot]);
            r = '0;
            r.result_kind = 1'b1;
            r.particle_out = it.particle;
            if (scan_total == 0) r.zero_total = 1'b1;
            else if (w >= scan_total) r.weight_out = 32'hFFFF_FFFF;
            else begin
                q = (w << 32) / scan_total;
                r.weight_out = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            end
            expected_results = {expected_results, r};
            return;
        end
        if (!it.observed_infinite && !it.expected_infinite) begin
            pz = beam_probability(64'(it.observed_range), 64'(it.expected_range));
            cube = (((pz * pz) >> 16) * pz) >> 16;
            beam_sum += cube;
            if (beam_sum > 64'hFFFF_FFFF) beam_sum = 64'hFFFF_FFFF;
        end
        if (!it.last_beam) return;
        p = beam_sum / ((k_beams != 0) ? k_beams : 64'd1);
        w = (64'(it.prior_weight) * p) >> 16;
        if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
        weight_mem[slot] = w[31:0];
        scan_total += w;
        if (scan_total > 64'hFFFF_FFFF_FFFF) scan_total = 64'hFFFF_FFFF_FFFF;
        beam_sum = 0;
        r = '0;
        r.particle_out = it.particle;
        r.weight_out = w[31:0];
        expected_results = {expected_results, r};
    endfunction

    // Driver: one transaction at a time from the pending queue, with random gaps.
    int send_gap = 0;
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            predict_weight(s_data);
            void'(pending_items.pop_front());
            s_valid <= 1'b0;
            send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        end else if (!s_valid && aresetn) begin
            if (send_gap > 0) send_gap--;
            else if (pending_items.size() > 0) begin
                s_data <= pending_items[0];
                s_valid <= 1'b1;
            end
        end
    end

    // Monitor: checks each result against the oldest expectation.
    int recv_gap = 0;
    always @(posedge aclk) begin
        out_t want;
        if (m_valid && m_ready) begin
            result_count++;
            if (m_data.result_kind) read_count++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_data), 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (m_data.result_kind !== want.result_kind)
                    report_mismatch("result_kind", 64'(m_data.result_kind),
                                    64'(want.result_kind));
                if (m_data.particle_out !== want.particle_out)
                    report_mismatch("particle_out", 64'(m_data.particle_out),
                                    64'(want.particle_out));
                if (m_data.weight_out !== want.weight_out)
                    report_mismatch("weight_out", 64'(m_data.weight_out),
                                    64'(want.weight_out));
                if (m_data.zero_total !== want.zero_total)
                    report_mismatch("zero_total", 64'(m_data.zero_total),
                                    64'(want.zero_total));
            end
            recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            m_ready <= 1'b0;
        end else if (hold_off_long) begin
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn;
        end
    end

    task automatic write_register(input cfg_idx_t idx, input logic [19:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_HIT_MIX:    k_hit_mix = 64'(val[15:0]);
            CFG_SHORT_MIX:  k_short_mix = 64'(val[15:0]);
            CFG_MAX_MIX:    k_max_mix = 64'(val[15:0]);
            CFG_RAND_MIX:   k_rand_mix = 64'(val[15:0]);
            CFG_HIT_SIGMA:  k_sigma = 64'(val[15:0]);
            CFG_SHORT_RATE: k_rate = 64'(val[15:0]);
            CFG_MAX_RANGE:  k_max_range = 64'(val);
            CFG_BEAMS:      k_beams = 64'(val[10:0]);
            default: ;
        endcase
    endtask

    // Waits until the block has drained; a non-last infinite beam gives no
    // result, so a margin follows the last expected one.
    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    function automatic in_t make_beam(input logic [9:0] part, input logic [19:0] obs,
                                      input logic [19:0] expd, input bit last,
                                      input bit start);
        in_t it;
        it = '0;
        it.particle = part;
        it.observed_range = obs;
        it.expected_range = expd;
        it.prior_weight = $urandom();
        it.last_beam = last;
        it.scan_start = start;
        return it;
    endfunction

    function automatic in_t make_read(input logic [9:0] part, input bit start);
        in_t it;
        it = '0;
        it.kind = 1'b1;
        it.particle = part;
        it.scan_start = start;
        it.observed_range = 20'($urandom());
        it.expected_range = 20'($urandom());
        it.prior_weight = $urandom();
        it.observed_infinite = 1'($urandom());
        it.expected_infinite = 1'($urandom());
        it.last_beam = 1'($urandom());
        return it;
    endfunction

    // Random range: mostly near the expected one, else max range, below it or anywhere.
    function automatic logic [19:0] pick_observed(input logic [19:0] expd);
        int d;
        case ($urandom_range(0, 5))
            0: return 20'($urandom());
            1: return k_max_range[19:0];
            2: return expd - 20'($urandom_range(0, 4096));
            default: begin
                d = $urandom_range(0, 1200);
                return expd + 20'(d) - 20'd600;
            end
        endcase
    endfunction

    // One scan: several particles with a few beams each, then some reads.
    task automatic queue_scan(input int particles, input bit wide_index);
        logic [9:0] parts[$];
        logic [9:0] p;
        logic [19:0] expd;
        int nb;
        in_t it;
        for (int i = 0; i < particles; i++) begin
            p = wide_index ? 10'($urandom()) : 10'($urandom_range(0, 31));
            parts = {parts, p};
            nb = $urandom_range(1, 4);
            for (int b = 0; b < nb; b++) begin
                expd = (k_max_range > 64) ? 20'($urandom_range(0, 32'(k_max_range)))
                                          : 20'($urandom());
                it = make_beam(p, pick_observed(expd), expd, b == nb - 1,
                               i == 0 && b == 0);
                it.observed_infinite = ($urandom_range(0, 15) == 0);
                it.expected_infinite = ($urandom_range(0, 15) == 0);
                if ($urandom_range(0, 9) == 0) it.prior_weight = 32'hFFFF_FFFF;
                pending_items = {pending_items, it};
            end
        end
        for (int i = 0; i < particles / 2 + 1; i++)
            pending_items = {pending_items,
                             make_read(parts[$urandom_range(0, parts.size() - 1)],
                                       $urandom_range(0, 30) == 0)};
    endtask

    task automatic randomize_config(input int mode);
        write_register(CFG_HIT_MIX, mode == 0 ? 20'd65535 : 20'($urandom_range(0, 65535)));
        write_register(CFG_SHORT_MIX, 20'($urandom_range(0, 65535)));
        write_register(CFG_MAX_MIX, 20'($urandom_range(0, 65535)));
        write_register(CFG_RAND_MIX, mode == 1 ? 20'd0 : 20'($urandom_range(0, 65535)));
        write_register(CFG_HIT_SIGMA, mode == 0 ? 20'd0 : 20'($urandom_range(1, 2000)));
        write_register(CFG_SHORT_RATE, mode == 1 ? 20'd65535 : 20'($urandom_range(0, 3000)));
        write_register(CFG_MAX_RANGE, mode == 0 ? 20'd0 :
                       mode == 1 ? 20'hFFFFF : 20'($urandom_range(1000, 100000)));
        write_register(CFG_BEAMS, mode == 0 ? 20'd0 : mode == 1 ? 20'd1024 :
                       20'($urandom_range(1, 2047)));
    endtask

    initial begin
        int scans;
        in_t it;
        build_exp_lut();
        k_hit_mix = 32768; k_short_mix = 6554; k_max_mix = 3277; k_rand_mix = 6554;
        k_sigma = 205; k_rate = 25; k_max_range = 30720; k_beams = 60;
        beam_sum = 0; scan_total = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset configuration.
        pending_items = {pending_items, make_read(10'd5, 1'b1)};          // zero total
        pending_items = {pending_items,
                         make_beam(10'd5, 20'd30720, 20'd30720, 0, 1)};  // max range
        pending_items = {pending_items,
                         make_beam(10'd5, 20'd1000, 20'd5000, 0, 0)};    // short
        it = make_beam(10'd5, 20'hFFFFF, 20'd0, 0, 0);
        it.observed_infinite = 1'b1;
        pending_items = {pending_items, it};                               // infinite, not last
        it = make_beam(10'd5, 20'd0, 20'hFFFFF, 1, 0);
        it.expected_infinite = 1'b1;
        it.prior_weight = 32'hFFFF_FFFF;
        pending_items = {pending_items, it};                               // infinite last
        pending_items = {pending_items, make_beam(10'd1023, 20'd2000, 20'd2000, 1, 0)};
        pending_items = {pending_items, make_read(10'd5, 1'b0)};
        pending_items = {pending_items, make_read(10'd1023, 1'b0)};
        pending_items = {pending_items, make_beam(10'd1023, 20'd0, 20'd0, 1, 1)};
        pending_items = {pending_items, make_read(10'd1023, 1'b0)};       // weight equals total
        it = make_beam(10'd0, 20'd100, 20'd100, 1, 0);
        it.prior_weight = 32'd0;
        pending_items = {pending_items, it};
        pending_items = {pending_items, make_read(10'd0, 1'b0)};
        wait_drained();

        // Register extremes, then random settings, each with several scans.
        for (int phase = 0; phase < 8; phase++) begin
            randomize_config(phase);
            scans = (phase < 2) ? 3 : 8;
            for (int s = 0; s < scans; s++) queue_scan($urandom_range(2, 8), phase == 3);
            if (phase == 4) begin
                // Long receiver hold-off while the sender keeps offering.
                hold_off_long = 1'b1;
                repeat (400) @(posedge aclk);
                hold_off_long = 1'b0;
            end
            wait_drained();
        end
        // Restore reset values, so every register sees a mid value again.
        write_register(CFG_HIT_MIX, 20'd32768);
        write_register(CFG_SHORT_MIX, 20'd6554);
        write_register(CFG_MAX_MIX, 20'd3277);
        write_register(CFG_RAND_MIX, 20'd6554);
        write_register(CFG_HIT_SIGMA, 20'd205);
        write_register(CFG_SHORT_RATE, 20'd25);
        write_register(CFG_MAX_RANGE, 20'd30720);
        write_register(CFG_BEAMS, 20'd60);
        for (int s = 0; s < 18; s++) queue_scan($urandom_range(2, 8), (s % 2) == 1);
        wait_drained();

        $display("Covered %0d results (%0d normalized reads) across nine register settings,",
                 result_count, read_count);
        $display("including zero and saturating extremes and a long output stall.");
        if (error_count == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== beam_likelihood_weighting_unit.f =====
rtl/core/blw_pkg.sv
rtl/core/blw_ram.sv
rtl/core/blw_div.sv
rtl/core/blw_dp.sv
rtl/core/blw_ctrl.sv
rtl/core/beam_likelihood_weighting_unit.sv
rtl/core/blw_chk.sv
tb/testbench.sv
